// ===== src/awm_pkg.sv =====
// ----------------------------------------------------------------------------
// awm_pkg: shared definitions for the anagram window matcher
// Request codes, field widths, parameter defaults and the per-letter lane
// control bundle.
// ----------------------------------------------------------------------------
package awm_pkg;

	// Field widths of the request and result channels.
	localparam int REQ_W    = 2;
	localparam int LETTER_W = 5;

	// Defaults for the top-level parameters.
	localparam int MAX_PATTERN_DEF = 64;
	localparam int ALPHABET_DEF    = 26;

	// Request codes; the fourth code is unused and changes nothing.
	localparam logic [REQ_W-1:0] REQ_CLEAR   = 2'd0;
	localparam logic [REQ_W-1:0] REQ_PATTERN = 2'd1;
	localparam logic [REQ_W-1:0] REQ_TEXT    = 2'd2;

	// Update controls for one letter's pair of counters.
	typedef struct packed {
		logic clr;
		logic pat_inc;
		logic win_inc;
		logic win_dec;
	} lane_ctl_t;

endpackage

// ===== src/awm_ram.sv =====
// ----------------------------------------------------------------------------
// awm_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle; the read data is registered, and a read
// at the address being written returns the old contents.
// ----------------------------------------------------------------------------
module awm_ram #(
	parameter int WIDTH = 5,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

// ===== src/awm_cell.sv =====
// ----------------------------------------------------------------------------
// awm_cell: counters for one letter
// Holds the pattern count and the window count of a single letter and tells
// whether the two will be equal once this cycle's update is applied.
// ----------------------------------------------------------------------------
module awm_cell #(
	parameter int CW = 7
) (
	input  logic              clk,
	input  logic              arst_n,
	input  awm_pkg::lane_ctl_t ctl,
	output logic              eq_next
);

	import awm_pkg::*;

	logic [CW-1:0] pat_cnt_q;
	logic [CW-1:0] win_cnt_q;
	logic [CW-1:0] pat_cnt_d;
	logic [CW-1:0] win_cnt_d;
	logic          win_sub;

	// Next counts; the window count never drops below zero.
	always_comb begin
		win_sub = ctl.win_dec && (win_cnt_q != '0);
		if (ctl.clr) begin
			pat_cnt_d = '0;
			win_cnt_d = '0;
		end else begin
			pat_cnt_d = pat_cnt_q + CW'(ctl.pat_inc);
			win_cnt_d = win_cnt_q + CW'(ctl.win_inc) - CW'(win_sub);
		end
	end

	assign eq_next = (pat_cnt_d == win_cnt_d);

	// Count registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_cnt_q <= '0;
			win_cnt_q <= '0;
		end else begin
			pat_cnt_q <= pat_cnt_d;
			win_cnt_q <= win_cnt_d;
		end
	end

endmodule

// ===== src/anagram_window_matcher.sv =====
// ----------------------------------------------------------------------------
// anagram_window_matcher: sliding-window anagram search
// Counts pattern letters into one histogram and the last pattern-length text
// letters into another, and reports per request whether the two are equal.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake             Payload
// request   in         req_valid/req_stall   req_type, letter
// result    out        res_valid/res_stall   window_match, found, overflow
//
// Each request waits in the input register and yields its result in the output
// register; one request per cycle sustained while no result is stalled.
// The rate is set by the one read-modify-write of the letter lanes per request
// and the single read of the recent-letter RAM, prefetched for the next request.
// A stalled result holds the output register; the input register still takes
// a request while the result register is free or being emptied.
// After reset every count and flag is zero; the RAM needs no clearing pass.
//
module anagram_window_matcher #(
	parameter int MAX_PATTERN = awm_pkg::MAX_PATTERN_DEF,
	parameter int ALPHABET    = awm_pkg::ALPHABET_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        req_valid,
	output logic                        req_stall,
	input  logic [awm_pkg::REQ_W-1:0]    req_type,
	input  logic [awm_pkg::LETTER_W-1:0] letter,
	output logic                        res_valid,
	input  logic                        res_stall,
	output logic                        window_match,
	output logic                        found,
	output logic                        overflow
);

	import awm_pkg::*;

	localparam int CW = $clog2(MAX_PATTERN + 1);
	localparam int AW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
	localparam int DW = CW + 1;

	// Input register.
	logic                valid_s1;
	logic [REQ_W-1:0]    type_s1;
	logic [LETTER_W-1:0] letter_s1;

	// Block state.
	logic [CW-1:0] plen_q;
	logic [CW-1:0] fill_q;
	logic [AW-1:0] ptr_q;
	logic          found_q;
	logic          ovf_q;
	logic [CW-1:0] plen_d;
	logic [CW-1:0] fill_d;
	logic [AW-1:0] ptr_d;
	logic          found_d;
	logic          ovf_d;

	// Ring read path and same-address bypass.
	logic [AW-1:0]       rd_addr;
	logic [LETTER_W-1:0] ram_rdata;
	logic                byp_q;
	logic [LETTER_W-1:0] byp_data_q;
	logic [LETTER_W-1:0] old_letter;
	logic [DW-1:0]       back_diff;

	// Decode.
	logic advance;
	logic load_s1;
	logic in_range;
	logic is_clr;
	logic pat_ok;
	logic pat_add;
	logic ovf_set;
	logic txt_ok;
	logic txt_act;
	logic leave;
	logic fill_inc;
	logic match_next;

	lane_ctl_t             lane_ctl [ALPHABET];
	logic [ALPHABET-1:0]   lane_eq;

	// Handshake: the input register moves on whenever the result register is
	// empty or its result is being taken.
	assign advance   = valid_s1 && (!res_valid || !res_stall);
	assign req_stall = valid_s1 && !advance;
	assign load_s1   = req_valid && !req_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load_s1) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			type_s1   <= req_type;
			letter_s1 <= letter;
		end
	end

	// Request decode for the item in the input register.
	always_comb begin
		in_range = (32'(letter_s1) < ALPHABET);
		is_clr   = advance && (type_s1 == REQ_CLEAR);
		pat_ok   = advance && (type_s1 == REQ_PATTERN) && in_range;
		pat_add  = pat_ok && (plen_q != CW'(MAX_PATTERN));
		ovf_set  = pat_ok && !pat_add;
		txt_ok   = advance && (type_s1 == REQ_TEXT) && in_range;
		txt_act  = txt_ok && (plen_q != '0);
		leave    = txt_act && (fill_q >= plen_q);
		fill_inc = txt_act && !leave;
	end

	// The letter leaving the window comes from the prefetched ring read.
	assign old_letter = byp_q ? byp_data_q : ram_rdata;

	// One lane per letter.
	for (genvar k = 0; k < ALPHABET; k++) begin : g_lane
		always_comb begin
			lane_ctl[k].clr     = is_clr;
			lane_ctl[k].pat_inc = pat_add && (32'(letter_s1) == k);
			lane_ctl[k].win_inc = txt_act && (32'(letter_s1) == k);
			lane_ctl[k].win_dec = leave && (32'(old_letter) == k);
		end

		awm_cell #(
			.CW (CW)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl     (lane_ctl[k]),
			.eq_next (lane_eq[k])
		);
	end

	assign match_next = &lane_eq;

	// Next state.
	always_comb begin
		if (is_clr) begin
			plen_d  = '0;
			fill_d  = '0;
			ptr_d   = '0;
			found_d = 1'b0;
			ovf_d   = 1'b0;
		end else begin
			plen_d  = plen_q + CW'(pat_add);
			fill_d  = fill_q + CW'(fill_inc);
			found_d = found_q || (txt_ok && match_next);
			ovf_d   = ovf_q || ovf_set;
			if (!txt_act) begin
				ptr_d = ptr_q;
			end else if (ptr_q == AW'(MAX_PATTERN - 1)) begin
				ptr_d = '0;
			end else begin
				ptr_d = ptr_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plen_q  <= '0;
			fill_q  <= '0;
			ptr_q   <= '0;
			found_q <= 1'b0;
			ovf_q   <= 1'b0;
		end else begin
			plen_q  <= plen_d;
			fill_q  <= fill_d;
			ptr_q   <= ptr_d;
			found_q <= found_d;
			ovf_q   <= ovf_d;
		end
	end

	// Prefetch address for the next request: the entry written pattern-length
	// letters before the next write position, wrapped into the ring.
	always_comb begin
		back_diff = DW'(ptr_d) - DW'(plen_d);
		if (back_diff[DW-1]) begin
			back_diff = back_diff + DW'(MAX_PATTERN);
		end
		rd_addr = AW'(back_diff);
	end

	awm_ram #(
		.WIDTH (LETTER_W),
		.DEPTH (MAX_PATTERN)
	) u_ring (
		.clk     (clk),
		.wr_en   (txt_act),
		.wr_addr (ptr_q),
		.wr_data (letter_s1),
		.rd_addr (rd_addr),
		.rd_data (ram_rdata)
	);

	// A read of the entry written in the same cycle takes the new letter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byp_q <= 1'b0;
		end else begin
			byp_q <= txt_act && (ptr_q == rd_addr);
		end
	end

	always_ff @(posedge clk) begin
		byp_data_q <= letter_s1;
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid <= 1'b0;
		end else if (advance) begin
			res_valid <= 1'b1;
		end else if (!res_stall) begin
			res_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			window_match <= match_next && !is_clr;
			found        <= found_d;
			overflow     <= ovf_d;
		end
	end

endmodule

// ===== src/awm_checker.sv =====
// ----------------------------------------------------------------------------
// awm_checker: port-level checks for the anagram window matcher
// Tracks requests in flight and the last delivered flags, and checks the
// capacity of the block and the stickiness of its flags between clears.
// ----------------------------------------------------------------------------
module awm_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        req_valid,
	input logic                        req_stall,
	input logic [awm_pkg::REQ_W-1:0]    req_type,
	input logic [awm_pkg::LETTER_W-1:0] letter,
	input logic                        res_valid,
	input logic                        res_stall,
	input logic                        window_match,
	input logic                        found,
	input logic                        overflow
);

	import awm_pkg::*;

	logic       in_acc;
	logic       out_acc;
	logic [1:0] in_flight_q;
	logic       last_found_q;
	logic       last_ovf_q;
	logic       clr_seen_q;

	assign in_acc  = req_valid && !req_stall;
	assign out_acc = res_valid && !res_stall;

	// Requests accepted but not yet answered, and flags of the last result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_flight_q  <= '0;
			last_found_q <= 1'b0;
			last_ovf_q   <= 1'b0;
			clr_seen_q   <= 1'b0;
		end else begin
			in_flight_q <= in_flight_q + 2'(in_acc) - 2'(out_acc);
			if (out_acc) begin
				last_found_q <= found;
				last_ovf_q   <= overflow;
			end
			if (in_acc && (req_type == REQ_CLEAR) && (letter == letter)) begin
				clr_seen_q <= 1'b1;
			end
		end
	end

	// A stalled result stays put.
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(window_match)
			&& $stable(found) && $stable(overflow))
		else $error("result changed while stalled");

	// The block holds at most one request in the input register and one result.
	a_capacity: assert property (@(posedge clk) disable iff (!arst_n)
		in_flight_q != 2'd3)
		else $error("more than two requests in flight");

	// A result is only shown for a request that was accepted.
	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> in_flight_q != 2'd0)
		else $error("result without an accepted request");

	// The found flag drops only at a clear result, which is all zero.
	a_found_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc && last_found_q && !found |-> !window_match && !overflow && clr_seen_q)
		else $error("found flag dropped outside a clear");

	// The overflow flag drops only at a clear result, which is all zero.
	a_ovf_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc && last_ovf_q && !overflow |-> !window_match && !found && clr_seen_q)
		else $error("overflow flag dropped outside a clear");

endmodule

bind anagram_window_matcher awm_checker u_awm_checker (.*);

// ===== tb/tb_anagram_window_matcher.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_anagram_window_matcher: self-checking testbench for the anagram matcher
// Sends clear, pattern and text requests with random gaps and result stalls.
// A behavioral copy of both histograms, the letter ring and the sticky flags
// predicts every result, and each result is checked field by field in order.
// ----------------------------------------------------------------------------
module tb_anagram_window_matcher;
	import awm_pkg::*;

	localparam int MAXP         = MAX_PATTERN_DEF;
	localparam int ALPHA        = ALPHABET_DEF;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int RANDOM_ITEMS = 1200;
	localparam int DRAIN_CYCLES = 8;
	localparam int PRINT_CAP    = 40;
	// The fourth request code has no name in the package.
	localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

	typedef struct packed {
		logic window_match;
		logic found;
		logic overflow;
	} match_flags_t;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                req_valid;
	logic                req_stall;
	logic [REQ_W-1:0]    req_type;
	logic [LETTER_W-1:0] letter;
	logic                res_valid;
	logic                res_stall;
	logic                window_match;
	logic                found;
	logic                overflow;

	// Behavioral copy of the matcher state.
	logic [6:0] pat_hist [ALPHA];
	logic [6:0] win_hist [ALPHA];
	logic [6:0] pat_len;
	logic [6:0] win_fill;
	logic [4:0] ring [MAXP];
	logic [5:0] ring_ptr;
	logic       found_q;
	logic       ovf_q;

	match_flags_t pending_flags [$];

	int  cycle_count = 0;
	int  n_errors    = 0;
	int  n_sent      = 0;
	int  n_results   = 0;
	int  n_matches   = 0;
	int  n_sequences = 0;
	bit  idle_on     = 1'b1;
	bit  stall_on    = 1'b1;

	anagram_window_matcher u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (req_valid),
		.req_stall    (req_stall),
		.req_type     (req_type),
		.letter       (letter),
		.res_valid    (res_valid),
		.res_stall    (res_stall),
		.window_match (window_match),
		.found        (found),
		.overflow     (overflow)
	);

	always #6 clk = ~clk;

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count = cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d results outstanding",
				cycle_count, pending_flags.size());
			$display("Test completed with failures");
			$finish;
		end
	end

	// Return the prediction to the state after reset or a clear request.
	function automatic void clear_model();
		for (int k = 0; k < ALPHA; k++) begin
			pat_hist[k] = '0;
			win_hist[k] = '0;
		end
		for (int k = 0; k < MAXP; k++)
			ring[k] = '0;
		pat_len  = '0;
		win_fill = '0;
		ring_ptr = '0;
		found_q  = 1'b0;
		ovf_q    = 1'b0;
	endfunction

	function automatic logic hists_agree();
		for (int k = 0; k < ALPHA; k++)
			if (pat_hist[k] != win_hist[k])
				return 1'b0;
		return 1'b1;
	endfunction

	// Apply one request to the behavioral state and return the flags it yields.
	function automatic match_flags_t predict_request(logic [REQ_W-1:0] kind,
			logic [LETTER_W-1:0] ltr);
		match_flags_t r;
		logic [5:0]   back;
		logic [4:0]   gone;
		if (kind == REQ_CLEAR) begin
			clear_model();
			return '0;
		end
		// Pattern letters count until the pattern is full, then only flag.
		if (kind == REQ_PATTERN && 32'(ltr) < ALPHA) begin
			if (32'(pat_len) < MAXP) begin
				pat_hist[ltr] = pat_hist[ltr] + 1'b1;
				pat_len       = pat_len + 1'b1;
			end else begin
				ovf_q = 1'b1;
			end
		end
		r.window_match = hists_agree();
		// Text letters slide the window once a pattern exists.
		if (kind == REQ_TEXT && 32'(ltr) < ALPHA) begin
			if (pat_len != '0) begin
				if (win_fill >= pat_len) begin
					back = ring_ptr - pat_len[5:0];
					gone = ring[back];
					if (32'(gone) < ALPHA && win_hist[gone] != '0)
						win_hist[gone] = win_hist[gone] - 1'b1;
				end else begin
					win_fill = win_fill + 1'b1;
				end
				win_hist[ltr]  = win_hist[ltr] + 1'b1;
				ring[ring_ptr] = ltr;
				ring_ptr       = ring_ptr + 1'b1;
			end
			r.window_match = hists_agree();
			if (r.window_match)
				found_q = 1'b1;
		end
		r.found    = found_q;
		r.overflow = ovf_q;
		return r;
	endfunction

	task automatic report_mismatch(string what, logic got, logic want);
		if (n_errors < PRINT_CAP)
			$display("MISMATCH cycle %0d result %0d: %s got %b expected %b",
				cycle_count, n_results, what, got, want);
		n_errors++;
	endtask

	// Send one request after a random gap; valid stays high for a following request.
	task automatic send_request(logic [REQ_W-1:0] kind, logic [LETTER_W-1:0] ltr);
		int gap;
		gap = idle_on ? $urandom_range(0, 9) : 0;
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req_type  <= kind;
		letter    <= ltr;
		do @(posedge clk); while (req_stall);
		pending_flags.push_back(predict_request(kind, ltr));
		n_sent++;
	endtask

	// Hold off new requests until every predicted result has come back.
	task automatic wait_results_drained();
		req_valid <= 1'b0;
		while (pending_flags.size() != 0) @(posedge clk);
		@(posedge clk);
	endtask

	// Result checker.
	always @(posedge clk) begin
		match_flags_t want;
		if (arst_n && res_valid && !res_stall) begin
			if (pending_flags.size() == 0) begin
				report_mismatch("result with no request pending", 1'b1, 1'b0);
			end else begin
				want = pending_flags.pop_front();
				if (window_match !== want.window_match)
					report_mismatch("window_match", window_match, want.window_match);
				if (found !== want.found)
					report_mismatch("found", found, want.found);
				if (overflow !== want.overflow)
					report_mismatch("overflow", overflow, want.overflow);
				if (want.window_match)
					n_matches++;
			end
			n_results++;
		end
	end

	// Result-side stall: a random hold before each result is taken.
	initial begin
		int hold;
		res_stall <= 1'b0;
		@(posedge arst_n);
		forever begin
			hold = stall_on ? $urandom_range(0, 9) : 0;
			if (hold > 0) begin
				res_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			res_stall <= 1'b0;
			do @(posedge clk); while (!(res_valid && !res_stall));
		end
	end

	// Hand-picked requests: empty pattern, short window, out-of-range letters,
	// the unused code, a match that persists and a pattern grown after text.
	task automatic test_directed();
		idle_on  = 1'b1;
		stall_on = 1'b1;
		send_request(REQ_CLEAR, 5'd0);
		send_request(REQ_TEXT, 5'd7);
		send_request(REQ_TEXT, 5'd31);
		send_request(REQ_CLEAR, 5'd31);
		send_request(REQ_PATTERN, 5'd0);
		send_request(REQ_PATTERN, 5'd25);
		send_request(REQ_PATTERN, 5'd2);
		send_request(REQ_PATTERN, 5'd26);
		send_request(REQ_UNUSED, 5'd3);
		send_request(REQ_TEXT, 5'd2);
		send_request(REQ_TEXT, 5'd25);
		send_request(REQ_TEXT, 5'd0);
		send_request(REQ_TEXT, 5'd2);
		send_request(REQ_TEXT, 5'd30);
		send_request(REQ_TEXT, 5'd1);
		send_request(REQ_PATTERN, 5'd1);
		send_request(REQ_TEXT, 5'd25);
		send_request(REQ_TEXT, 5'd0);
		send_request(REQ_UNUSED, 5'd31);
		send_request(REQ_CLEAR, 5'd0);
		wait_results_drained();
	endtask

	// Fill the pattern to its limit and past it, then slide a full-length window
	// over an anagram of it so the ring wraps at its largest distance.
	task automatic test_overflow();
		logic [4:0] pat [$];
		idle_on  = 1'b0;
		stall_on = 1'b1;
		send_request(REQ_CLEAR, 5'd0);
		for (int i = 0; i < MAXP + 2; i++) begin
			pat.push_back(5'($urandom_range(0, 25)));
			send_request(REQ_PATTERN, pat[i]);
		end
		for (int i = 0; i < 20; i++)
			send_request(REQ_TEXT, 5'($urandom_range(0, 25)));
		for (int i = MAXP - 1; i >= 0; i--)
			send_request(REQ_TEXT, pat[i]);
		for (int i = 0; i < 20; i++)
			send_request(REQ_TEXT, pat[$urandom_range(0, MAXP - 1)]);
		wait_results_drained();
	endtask

	// Random sequences: clear, a pattern, then text that mostly reuses the
	// pattern letters and embeds a shuffled copy, with noise mixed in.
	task automatic test_random();
		int         target;
		int         pick;
		int         plen;
		int         tlen;
		int         span;
		int         embed_at;
		int         j;
		logic [4:0] tmp;
		logic [4:0] pat [$];
		logic [4:0] shuf [$];
		target = n_sent + RANDOM_ITEMS;
		while (n_sent < target) begin
			n_sequences++;
			idle_on  = ($urandom_range(0, 3) != 0);
			stall_on = ($urandom_range(0, 3) != 0);
			send_request(REQ_CLEAR, 5'($urandom_range(0, 31)));
			pick = $urandom_range(0, 99);
			if (pick < 5)
				plen = 0;
			else if (pick < 78)
				plen = $urandom_range(1, 5);
			else if (pick < 93)
				plen = $urandom_range(6, 24);
			else if (pick < 97)
				plen = $urandom_range(25, MAXP);
			else
				plen = $urandom_range(MAXP + 1, MAXP + 6);
			span = $urandom_range(1, 25);
			pat.delete();
			// Pattern letters with a little noise between them.
			for (int i = 0; i < plen; i++) begin
				pat.push_back(5'($urandom_range(0, span)));
				send_request(REQ_PATTERN, pat[i]);
				pick = $urandom_range(0, 99);
				if (pick < 3)
					send_request(REQ_PATTERN, 5'($urandom_range(26, 31)));
				else if (pick < 5)
					send_request(REQ_UNUSED, 5'($urandom_range(0, 31)));
			end
			// Shuffled copy of the letters the block actually counted.
			shuf.delete();
			for (int i = 0; i < plen && i < MAXP; i++)
				shuf.push_back(pat[i]);
			for (int i = shuf.size() - 1; i > 0; i--) begin
				j       = $urandom_range(0, i);
				tmp     = shuf[i];
				shuf[i] = shuf[j];
				shuf[j] = tmp;
			end
			tlen     = (plen > 24) ? $urandom_range(plen / 2, plen + 10)
				: $urandom_range(plen + 1, 3 * plen + 8);
			embed_at = $urandom_range(0, tlen);
			for (int t = 0; t <= tlen; t++) begin
				if (t == embed_at) begin
					foreach (shuf[k])
						send_request(REQ_TEXT, shuf[k]);
				end
				pick = $urandom_range(0, 99);
				if (pick < 4)
					send_request(REQ_TEXT, 5'($urandom_range(26, 31)));
				else if (pick < 7)
					send_request(REQ_UNUSED, 5'($urandom_range(0, 31)));
				else if (pick < 10)
					send_request(REQ_PATTERN, 5'($urandom_range(0, span)));
				else if (pick < 11)
					send_request(REQ_CLEAR, 5'($urandom_range(0, 31)));
				else if (pick < 75 && plen > 0)
					send_request(REQ_TEXT, pat[$urandom_range(0, plen - 1)]);
				else
					send_request(REQ_TEXT, 5'($urandom_range(0, 25)));
			end
			if ($urandom_range(0, 7) == 0)
				wait_results_drained();
		end
	endtask

	initial begin
		arst_n    <= 1'b0;
		req_valid <= 1'b0;
		req_type  <= REQ_CLEAR;
		letter    <= '0;
		clear_model();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_overflow();
		test_random();

		wait_results_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d requests in %0d random sequences plus directed and overflow runs,",
			n_sent, n_sequences);
		$display("checked %0d results, %0d of them window matches, %0d mismatches.",
			n_results, n_matches, n_errors);
		if (n_errors == 0 && pending_flags.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

// ===== filelist.f =====
src/awm_pkg.sv
src/awm_ram.sv
src/awm_cell.sv
src/anagram_window_matcher.sv
src/awm_checker.sv
tb/tb_anagram_window_matcher.sv
